// ===== src/knps_pkg.sv =====
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and constants of the k-nearest point selector: request codes,
// the max_targets register format and the controller/datapath interface.
// ----------------------------------------------------------------------------
package knps_pkg;

    // request codes carried on req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // max_targets register
    localparam int          CFG_W             = 6;
    localparam logic [5:0]  MAX_TARGETS_RESET = 6'd1;
    localparam logic [5:0]  RESULT_LIMIT      = 6'd32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;      // append the input point to the store
        logic ovf_set;      // load dropped, store full
        logic query_cap;    // capture the query origin
        logic rd_en;        // read the point store
        logic rd_best;      // read address is the current best index
        logic scan_issue;   // the read feeds the distance pipeline
        logic best_clear;   // start a new nearest search
        logic take_best;    // mark the best point as taken
        logic res_load;     // load the output register
        logic res_none;     // result is the empty answer
        logic res_last;     // result closes the query
        logic store_clear;  // drop all points after the query
    } knps_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;         // store holds its maximum of points
        logic out_free;     // output register can take a result this cycle
        logic pipe_busy;    // distance pipeline still holds points
    } knps_stat_t;

endpackage

// ===== src/knps_ram.sv =====
// ----------------------------------------------------------------------------
// knps_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module knps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/knps_ctrl.sv =====
// ----------------------------------------------------------------------------
// knps_ctrl
// Controller of the point selector: input handshake, max_targets register,
// load handling and the sequencing of dump, scan and select passes.
// ----------------------------------------------------------------------------
module knps_ctrl
    import knps_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_W-1:0]                cfg_data,
    input  knps_stat_t                      stat,
    input  logic [$clog2(MAX_POINTS+1)-1:0] count,
    output knps_cmd_t                       cmd,
    output logic [$clog2(MAX_POINTS)-1:0]   rd_idx
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_DUMP_RD = 3'd2;
    localparam logic [2:0] ST_DUMP_WR = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_DRAIN   = 3'd5;
    localparam logic [2:0] ST_SEL_RD  = 3'd6;
    localparam logic [2:0] ST_SEL_WR  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CFG_W-1:0] sel_reg, sel_next;
    logic [CFG_W-1:0] k_reg, k_next;
    logic [CFG_W-1:0] max_targets_reg, max_targets_next;

    logic [CFG_W-1:0] k_cap;
    logic [CNT_W-1:0] idx_plus;
    logic [CFG_W-1:0] sel_plus;
    logic             idx_last;
    logic             sel_last;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign rd_idx    = idx_reg[IDX_W-1:0];

    assign k_cap    = (max_targets_reg > RESULT_LIMIT) ? RESULT_LIMIT : max_targets_reg;
    assign idx_plus = idx_reg + CNT_W'(1);
    assign sel_plus = sel_reg + CFG_W'(1);
    assign idx_last = (idx_plus == count);
    assign sel_last = (sel_plus == k_reg);

    always_comb
    begin
        max_targets_next = max_targets_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_targets_next = cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        k_next     = k_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.ovf_set = stat.full;
                        cmd.load_wr = !stat.full;
                    end
                    else
                    begin
                        cmd.query_cap  = 1'b1;
                        cmd.best_clear = 1'b1;
                        idx_next       = '0;
                        sel_next       = '0;
                        k_next         = k_cap;
                        if ((count == '0) || (k_cap == '0))
                        begin
                            state_next = ST_EMPTY;
                        end
                        else if (CMP_W'(count) <= CMP_W'(k_cap))
                        begin
                            state_next = ST_DUMP_RD;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_none    = 1'b1;
                    cmd.res_last    = 1'b1;
                    cmd.store_clear = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DUMP_WR;
            end
            ST_DUMP_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_last = idx_last;
                    if (idx_last)
                    begin
                        cmd.store_clear = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_plus;
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                // one stored point enters the distance pipeline per cycle
                cmd.rd_en      = 1'b1;
                cmd.scan_issue = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_best = 1'b1;
                state_next  = ST_SEL_WR;
            end
            ST_SEL_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.take_best = 1'b1;
                    cmd.res_last  = sel_last;
                    if (sel_last)
                    begin
                        cmd.store_clear = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.best_clear = 1'b1;
                        sel_next       = sel_plus;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            sel_reg         <= '0;
            k_reg           <= '0;
            max_targets_reg <= MAX_TARGETS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            sel_reg         <= sel_next;
            k_reg           <= k_next;
            max_targets_reg <= max_targets_next;
        end
    end

    a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.out_free)
        else $error("result loaded into an occupied output register");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> !stat.full)
        else $error("point written into a full store");

    a_select_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL_RD) |-> !stat.pipe_busy)
        else $error("best point read before the scan finished");

endmodule

// ===== src/knps_dpath.sv =====
// ----------------------------------------------------------------------------
// knps_dpath
// Datapath of the point selector: point store, taken marks, squared distance
// pipeline, running nearest search and the output register.
// ----------------------------------------------------------------------------
module knps_dpath
    import knps_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  knps_cmd_t                       cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]   rd_idx,
    output knps_stat_t                      stat,
    output logic [$clog2(MAX_POINTS+1)-1:0] count,
    input  logic [ID_BITS-1:0]              point_id,
    input  logic [COORD_BITS-1:0]           pos_x,
    input  logic [COORD_BITS-1:0]           pos_y,
    input  logic [COORD_BITS-1:0]           pos_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ID_BITS-1:0]              target_id,
    output logic                            none_found,
    output logic                            overflowed,
    output logic                            last_result
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int WORD_W = ID_BITS + 3 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? -d : d;
        return m[COORD_BITS-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat_add(
        input logic [DIST_W-1:0] a,
        input logic [DIST_W-1:0] b
    );
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    // store control state
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [MAX_POINTS-1:0] taken_reg, taken_next;

    // query origin
    logic [COORD_BITS-1:0] org_x_reg, org_y_reg, org_z_reg;

    // point store
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [WORD_W-1:0] ram_rd_data;
    logic [ID_BITS-1:0]    rd_id;
    logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;

    // distance pipeline
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0]      i1_reg, i2_reg, i3_reg, i4_reg, i5_reg;
    logic [COORD_BITS-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [SQ_W-1:0]       sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIST_W-1:0]     sum_xy_reg, sq_z4_reg, dist_reg;

    // nearest search
    logic                  have_reg, have_next;
    logic [DIST_W-1:0]     best_d_reg, best_d_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic                  better;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]    target_id_reg;
    logic                  none_reg, ovf_out_reg, last_reg;

    assign ram_rd_addr = cmd.rd_best ? best_idx_reg : rd_idx;
    assign ram_wr_data = {point_id, pos_z, pos_y, pos_x};
    assign {rd_id, rd_z, rd_y, rd_x} = ram_rd_data;

    knps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load_wr),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // store bookkeeping
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        taken_next = taken_reg;
        if (cmd.load_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.ovf_set)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.take_best)
        begin
            taken_next[best_idx_reg] = 1'b1;
        end
        if (cmd.store_clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            taken_next = '0;
        end
    end

    // running minimum, strict compare keeps the earliest point on a tie
    assign better = v5_reg && (!have_reg || (dist_reg < best_d_reg));

    always_comb
    begin
        have_next     = have_reg;
        best_d_next   = best_d_reg;
        best_idx_next = best_idx_reg;
        if (cmd.best_clear)
        begin
            have_next = 1'b0;
        end
        else if (better)
        begin
            have_next     = 1'b1;
            best_d_next   = dist_reg;
            best_idx_next = i5_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            taken_reg     <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            taken_reg     <= taken_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
            // taken points never enter the search
            v1_reg        <= cmd.scan_issue && !taken_reg[rd_idx];
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_cap)
        begin
            org_x_reg <= pos_x;
            org_y_reg <= pos_y;
            org_z_reg <= pos_z;
        end
        i1_reg       <= rd_idx;
        i2_reg       <= i1_reg;
        i3_reg       <= i2_reg;
        i4_reg       <= i3_reg;
        i5_reg       <= i4_reg;
        mag_x_reg    <= abs_diff(rd_x, org_x_reg);
        mag_y_reg    <= abs_diff(rd_y, org_y_reg);
        mag_z_reg    <= abs_diff(rd_z, org_z_reg);
        sq_x_reg     <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
        sq_y_reg     <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
        sq_z_reg     <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
        sum_xy_reg   <= sat_add(DIST_W'(sq_x_reg), DIST_W'(sq_y_reg));
        sq_z4_reg    <= DIST_W'(sq_z_reg);
        dist_reg     <= sat_add(sum_xy_reg, sq_z4_reg);
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        if (cmd.res_load)
        begin
            target_id_reg <= cmd.res_none ? '0 : rd_id;
            none_reg      <= cmd.res_none;
            ovf_out_reg   <= ovf_reg;
            last_reg      <= cmd.res_last;
        end
    end

    assign count          = count_reg;
    assign stat.full      = (count_reg == CNT_W'(MAX_POINTS));
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

    assign out_valid   = out_valid_reg;
    assign target_id   = target_id_reg;
    assign none_found  = none_reg;
    assign overflowed  = ovf_out_reg;
    assign last_result = last_reg;

    a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_best |-> have_reg)
        else $error("point taken without a completed search");

    a_take_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_best |-> !taken_reg[best_idx_reg])
        else $error("search selected a point already taken");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

endmodule

// ===== src/k_nearest_point_select.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_select
// Stores candidate points and answers a query with the ids of the nearest
// max_targets points, nearest first, by squared Euclidean distance.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | req_type, point_id, pos_x, pos_y, pos_z
//  out     | out_valid / out_stall| target_id, none_found, overflowed, last_result
//  cfg     | cfg_valid / cfg_ready| cfg_data (max_targets)
//
//  a query with n stored points and k = max_targets (capped at 32) returns all n in
//  load order when n <= k, else the k nearest, nearest first, each found by a scan
//  through the store's single read port, one point per cycle into the distance pipe
//  reset clears the store, the taken marks and the overflow flag; max_targets is 1
//  out_stall holds a result in the output register; loads still go in meanwhile
// ----------------------------------------------------------------------------
module k_nearest_point_select
    import knps_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [ID_BITS-1:0]    point_id,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [COORD_BITS-1:0] pos_z,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ID_BITS-1:0]    target_id,
    output logic                  none_found,
    output logic                  overflowed,
    output logic                  last_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);

    knps_cmd_t        cmd;
    knps_stat_t       stat;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] rd_idx;

    knps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .count     (count),
        .cmd       (cmd),
        .rd_idx    (rd_idx)
    );

    knps_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_idx      (rd_idx),
        .stat        (stat),
        .count       (count),
        .point_id    (point_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target_id   (target_id),
        .none_found  (none_found),
        .overflowed  (overflowed),
        .last_result (last_result)
    );

endmodule

// ===== dv/k_nearest_point_select_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_nearest_point_select_tb
// Self-checking bench for the k-nearest point selector. Candidate points and
// queries go in through a bursty driver, results are drawn out against a
// randomly stalling receiver, and every result is compared with a predictor
// that keeps its own point store and picks the nearest points itself.
// ----------------------------------------------------------------------------
module k_nearest_point_select_tb;
    import knps_pkg::*;

    localparam int MAX_POINTS    = 32;
    localparam int COORD_BITS    = 24;
    localparam int ID_BITS       = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 14;
    localparam int REPORT_LIMIT  = 10;
    localparam longint LIMIT_NS  = 4_000_000;

    typedef struct {
        logic                  req;
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } point_req_t;

    typedef struct {
        logic [ID_BITS-1:0] target_id;
        logic               none_found;
        logic               overflowed;
        logic               last_result;
    } target_result_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  req_type    = REQ_LOAD;
    logic [ID_BITS-1:0]    point_id    = '0;
    logic [COORD_BITS-1:0] pos_x       = '0;
    logic [COORD_BITS-1:0] pos_y       = '0;
    logic [COORD_BITS-1:0] pos_z       = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [ID_BITS-1:0]    target_id;
    logic                  none_found;
    logic                  overflowed;
    logic                  last_result;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data    = '0;

    // predictor copy of the point store
    logic [ID_BITS-1:0]           stored_ids [MAX_POINTS];
    logic signed [COORD_BITS-1:0] stored_x   [MAX_POINTS];
    logic signed [COORD_BITS-1:0] stored_y   [MAX_POINTS];
    logic signed [COORD_BITS-1:0] stored_z   [MAX_POINTS];
    int                           stored_count   = 0;
    bit                           store_overflow = 1'b0;
    logic [CFG_W-1:0]             max_targets_model = MAX_TARGETS_RESET;

    point_req_t     pending_requests [$];
    target_result_t expected_targets [$];
    point_req_t     driven_req;

    int queued_items     = 0;
    int load_count       = 0;
    int query_count      = 0;
    int overflow_queries = 0;
    int empty_answers    = 0;
    int results_checked  = 0;
    int check_failures   = 0;
    int settings_used    = 0;
    int burst_left       = 0;
    int gap_left         = 0;
    int stall_cycle      = 0;
    int stall_mode       = 0;

    k_nearest_point_select #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .point_id    (point_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target_id   (target_id),
        .none_found  (none_found),
        .overflowed  (overflowed),
        .last_result (last_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout: %0d results still expected, %0d items pending",
                 expected_targets.size(), pending_requests.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned sq_diff(logic signed [COORD_BITS-1:0] a,
                                                logic signed [COORD_BITS-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic target_result_t make_result(logic [ID_BITS-1:0] id, logic none,
                                                   logic last);
        target_result_t r;
        r.target_id   = id;
        r.none_found  = none;
        r.overflowed  = store_overflow;
        r.last_result = last;
        return r;
    endfunction

    // updates the store and queues the ids a query should give back
    task automatic select_nearest(input point_req_t r);
        int                           limit;
        int                           best;
        int                           produced;
        bit                           have;
        longint unsigned              best_dist;
        longint unsigned              cand_dist;
        logic [MAX_POINTS-1:0]        taken;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [COORD_BITS-1:0] oz;
        ox = r.x;
        oy = r.y;
        oz = r.z;
        produced = 0;
        taken = '0;
        if (r.req == REQ_LOAD)
        begin
            load_count++;
            if (stored_count >= MAX_POINTS)
                store_overflow = 1'b1;
            else
            begin
                stored_ids[stored_count] = r.id;
                stored_x[stored_count]   = ox;
                stored_y[stored_count]   = oy;
                stored_z[stored_count]   = oz;
                stored_count++;
            end
        end
        else
        begin
            query_count++;
            if (store_overflow)
                overflow_queries++;
            limit = (max_targets_model > RESULT_LIMIT) ? int'(RESULT_LIMIT)
                                                       : int'(max_targets_model);
            if (stored_count <= limit)
            begin
                for (int i = 0; i < stored_count; i++)
                begin
                    expected_targets.push_back(make_result(stored_ids[i], 1'b0,
                                                           i + 1 == stored_count));
                    produced++;
                end
            end
            else
            begin
                for (int t = 0; t < limit; t++)
                begin
                    have = 1'b0;
                    best = 0;
                    best_dist = 0;
                    for (int i = 0; i < stored_count; i++)
                    begin
                        if (!taken[i])
                        begin
                            cand_dist = sq_diff(stored_x[i], ox) + sq_diff(stored_y[i], oy)
                                      + sq_diff(stored_z[i], oz);
                            // strict compare keeps the earliest point on a tie
                            if (!have || cand_dist < best_dist)
                            begin
                                have = 1'b1;
                                best_dist = cand_dist;
                                best = i;
                            end
                        end
                    end
                    taken[best] = 1'b1;
                    expected_targets.push_back(make_result(stored_ids[best], 1'b0,
                                                           t + 1 == limit));
                    produced++;
                end
            end
            if (produced == 0)
            begin
                empty_answers++;
                expected_targets.push_back(make_result('0, 1'b1, 1'b1));
            end
            stored_count = 0;
            store_overflow = 1'b0;
        end
    endtask

    // input driver: bursts of items with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        point_req_t next_req;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                select_nearest(driven_req);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    driven_req <= next_req;
                    req_type   <= next_req.req;
                    point_id   <= next_req.id;
                    pos_x      <= next_req.x;
                    pos_y      <= next_req.y;
                    pos_z      <= next_req.z;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        target_result_t want;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_cycle <= 0;
            stall_mode  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_targets.size() == 0)
                begin
                    check_failures++;
                    if (check_failures <= REPORT_LIMIT)
                        $display("unexpected result: id=%h none=%b ovf=%b last=%b",
                                 target_id, none_found, overflowed, last_result);
                end
                else
                begin
                    want = expected_targets.pop_front();
                    results_checked++;
                    if (target_id !== want.target_id || none_found !== want.none_found ||
                        overflowed !== want.overflowed || last_result !== want.last_result)
                    begin
                        check_failures++;
                        if (check_failures <= REPORT_LIMIT)
                            $display("mismatch: expected id=%h none=%b ovf=%b last=%b, %s",
                                     want.target_id, want.none_found, want.overflowed,
                                     want.last_result,
                                     $sformatf("got id=%h none=%b ovf=%b last=%b",
                                               target_id, none_found, overflowed,
                                               last_result));
                    end
                end
            end
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_cycle % 3 == 0);
            endcase
        end
    end

    task automatic push_load(input logic [ID_BITS-1:0] id, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z);
        point_req_t r;
        r.req = REQ_LOAD;
        r.id  = id;
        r.x   = x;
        r.y   = y;
        r.z   = z;
        pending_requests.push_back(r);
        queued_items++;
    endtask

    task automatic push_query(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [COORD_BITS-1:0] z);
        point_req_t r;
        r.req = REQ_QUERY;
        r.id  = ID_BITS'($urandom);
        r.x   = x;
        r.y   = y;
        r.z   = z;
        pending_requests.push_back(r);
        queued_items++;
    endtask

    // sender holds off until the block has handed back everything it owes
    task automatic wait_for_quiet();
        while (pending_requests.size() > 0 || in_valid || expected_targets.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_max_targets(input logic [CFG_W-1:0] value);
        wait_for_quiet();
        // a trailing load leaves no result behind, give it time to land
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_targets_model = value;
        settings_used++;
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(bit spread);
        case ($urandom_range(0, 11))
            0: return {1'b1, {(COORD_BITS - 1){1'b0}}};
            1: return {1'b0, {(COORD_BITS - 1){1'b1}}};
            default:
                if (spread)
                    return COORD_BITS'($urandom);
                else
                    return COORD_BITS'($urandom_range(0, 12) - 6);
        endcase
    endfunction

    // loads with random content followed by a query
    task automatic queue_point_set();
        int                 n_loads;
        bit                 spread;
        logic [ID_BITS-1:0] id_base;
        n_loads = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        spread  = ($urandom_range(0, 2) == 0);
        id_base = ID_BITS'($urandom);
        for (int i = 0; i < n_loads; i++)
            push_load(id_base + ID_BITS'(i), pick_coord(spread), pick_coord(spread),
                      pick_coord(spread));
        push_query(pick_coord(spread), pick_coord(spread), pick_coord(spread));
        // now and then a second query that finds the store empty
        if ($urandom_range(0, 7) == 0)
            push_query(pick_coord(1'b1), pick_coord(1'b1), pick_coord(1'b1));
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] phase_targets [9];
        logic [COORD_BITS-1:0] c_min;
        logic [COORD_BITS-1:0] c_max;
        int phase_goal;
        int set_no;
        phase_targets = '{6'd1, 6'd5, 6'd32, 6'd0, 6'd63, 6'd2, 6'd33, 6'd31, 6'd0};
        phase_targets[8] = CFG_W'($urandom_range(0, 63));
        c_min = {1'b1, {(COORD_BITS - 1){1'b0}}};
        c_max = {1'b0, {(COORD_BITS - 1){1'b1}}};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // k of three: empty store, then a scan with corner points and a tie
        write_max_targets(6'd3);
        push_query('0, '0, '0);
        push_load(16'hFFFF, c_max, c_max, c_max);
        push_load(16'h0000, c_min, c_min, c_min);
        push_load(16'h0001, 24'd1, '0, '0);
        push_load(16'h0002, '0, -24'sd1, '0);
        push_load(16'h0003, '0, '0, 24'd2);
        push_load(16'h0004, '0, '0, '0);
        push_query('0, '0, '0);
        push_load(16'h5A5A, c_min, c_max, '0);
        push_load(16'hA5A5, 24'd1, 24'd2, 24'd3);
        push_query(c_max, c_max, c_max);

        // k of zero always answers empty
        write_max_targets(6'd0);
        push_load(16'h1234, 24'd7, 24'd7, 24'd7);
        push_load(16'h4321, c_min, '0, c_max);
        push_query('0, '0, '0);
        push_query(c_min, c_min, c_min);

        // k above the result limit, store returned in load order
        write_max_targets(6'd63);
        push_load(16'h8000, c_max, c_min, c_max);
        push_load(16'h7FFF, c_min, c_max, c_min);
        push_load(16'h00FF, '0, '0, '0);
        push_load(16'hFF00, 24'h00FFFF, 24'hFF0000, 24'h0F0F0F);
        push_query(c_min, c_min, c_min);

        for (int p = 0; p < 9; p++)
        begin
            write_max_targets(phase_targets[p]);
            phase_goal = queued_items + PHASE_ITEMS;
            set_no = 0;
            while (queued_items < phase_goal)
            begin
                queue_point_set();
                if (set_no == 0 || $urandom_range(0, 3) == 0)
                    wait_for_quiet();
                set_no++;
            end
        end

        wait_for_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d items: %0d loads, %0d queries over %0d max_targets settings",
                 queued_items, load_count, query_count, settings_used);
        $display("checked %0d results, %0d empty answers, %0d queries after dropped loads",
                 results_checked, empty_answers, overflow_queries);
        if (check_failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
